FILE: src/ps2mct_pkg.sv
// Package with the payload types, codes and constants of the PS/2 mouse cursor tracker.
package ps2mct_pkg;

	// Operation codes of an input item.
	localparam logic OP_MOUSE_BYTE = 1'b0;
	localparam logic OP_SET_POS    = 1'b1;

	// Configuration register indexes.
	localparam logic [7:0] REG_SCREEN_WIDTH   = 8'd0;
	localparam logic [7:0] REG_SCREEN_HEIGHT  = 8'd1;
	localparam logic [7:0] REG_MAX_STEP       = 8'd2;
	localparam logic [7:0] REG_CURSOR_VISIBLE = 8'd3;

	// Configuration reset values.
	localparam logic [7:0] SCREEN_WIDTH_RST  = 8'd80;
	localparam logic [7:0] SCREEN_HEIGHT_RST = 8'd25;
	localparam logic [6:0] MAX_STEP_RST      = 7'd3;

	// Motion scaling: mouse counts per cursor cell on each axis.
	localparam int X_DIVISOR = 6;
	localparam int Y_DIVISOR = 10;

	// Remainder saturation bound.
	localparam logic signed [16:0] REM_LIMIT = 17'sd32767;

	// Header byte bits.
	localparam int HDR_SYNC_BIT = 3;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
		logic [7:0] set_x;
		logic [7:0] set_y;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [2:0] buttons;
		logic       visible;
		logic       packet_done;
		logic       packet_rejected;
	} out_item_t;

endpackage

FILE: src/ps2mct_axis.sv
// Motion unit for one cursor axis: remainder update, constant division, step clamp and move.
module ps2mct_axis #(
	parameter int DIVISOR = 6
) (
	input  logic signed [15:0] rem,
	input  logic signed [8:0]  delta,
	input  logic [6:0]         max_step,
	input  logic [7:0]         pos,
	input  logic [7:0]         size,
	output logic signed [15:0] rem_next,
	output logic [7:0]         pos_next
);
	import ps2mct_pkg::*;

	// Reciprocal multiply that is exact for any 15-bit magnitude.
	localparam int SHIFT = 15 + $clog2(DIVISOR);
	localparam longint RECIP = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam int RW = $clog2(RECIP + 1);
	localparam int PW = 15 + RW;
	localparam int QW = PW - SHIFT;

	logic signed [16:0] sum;
	logic signed [15:0] sat;
	logic               neg;
	logic [15:0]        mag16;
	logic [14:0]        mag;
	logic [PW-1:0]      prod;
	logic [QW-1:0]      quot;
	logic [QW+6:0]      quot_ext;
	logic [QW+6:0]      max_ext;
	logic [6:0]         step;
	logic [15:0]        back;
	logic [9:0]         moved;
	logic [7:0]         top;

	always_comb begin
		sum = {rem[15], rem} + {{8{delta[8]}}, delta};
		if (sum > REM_LIMIT) begin
			sat = REM_LIMIT[15:0];
		end else if (sum < -REM_LIMIT) begin
			sat = 16'(-REM_LIMIT);
		end else begin
			sat = sum[15:0];
		end

		// Truncation toward zero: divide the magnitude, then restore the sign.
		neg   = sat[15];
		mag16 = neg ? (16'd0 - sat) : sat;
		mag   = mag16[14:0];
		prod  = PW'(mag) * PW'(RECIP);
		quot  = prod[PW-1:SHIFT];

		quot_ext = (QW+7)'(quot);
		max_ext  = (QW+7)'(max_step);
		step     = (quot_ext > max_ext) ? max_step : 7'(quot_ext);

		back     = 16'(int'(step) * DIVISOR);
		rem_next = neg ? (sat + back) : (sat - back);

		moved = neg ? ({2'b00, pos} - {3'b000, step}) : ({2'b00, pos} + {3'b000, step});
		top   = (size == 8'd0) ? 8'd0 : (size - 8'd1);
		if (moved[9]) begin
			pos_next = 8'd0;
		end else if (moved[8:0] > {1'b0, top}) begin
			pos_next = top;
		end else begin
			pos_next = moved[7:0];
		end
	end

endmodule

FILE: src/ps2_mouse_cursor_tracker.sv
// Top level of the PS/2 mouse cursor tracker: packet collection, cursor state and result register.
//
// The block takes raw PS/2 mouse bytes (or set-position commands) one transfer at a time
// and returns exactly one result per input transfer: the cursor column and row after that
// item, the button bits of the last accepted packet, the cursor visible flag and two packet
// flags. Every third mouse byte completes a packet; a packet whose header lacks the
// always-one bit 3 is reported as rejected and changes nothing. An accepted packet adds its
// X delta and the negated Y delta to saturating 16-bit remainders, divides them by 6 and 10
// respectively, limits the step to max_step and moves the cursor inside the screen. A
// set-position command loads the cursor unclamped and clears the remainders, leaving a
// packet in progress untouched. Each item waits in the input stage, where the whole update
// is done, until the result register is free, and then sits in the result register until
// taken; one item is accepted per cycle when the result side keeps up, and each result
// passes the input stage and then the result register. The configuration port is always
// ready; registers are to be written only while no result is outstanding, and writes to
// indexes above 3 are ignored.
module ps2_mouse_cursor_tracker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ps2mct_pkg::in_item_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ps2mct_pkg::out_item_t  out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_index,
	input  logic [7:0]             cfg_data
);
	import ps2mct_pkg::*;

	// Configuration registers.
	logic [7:0] scr_w_q;
	logic [7:0] scr_h_q;
	logic [6:0] max_step_q;
	logic       visible_q;

	// Tracker state.
	logic [1:0]        byte_idx_q;
	logic [7:0]        header_q;
	logic [7:0]        x_byte_q;
	logic signed [15:0] rem_x_q;
	logic signed [15:0] rem_y_q;
	logic [7:0]        cur_x_q;
	logic [7:0]        cur_y_q;
	logic [2:0]        buttons_q;

	// Input stage and result register.
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_q;
	logic      out_valid_q;

	logic advance;

	// Next state.
	logic [1:0]         byte_idx_n;
	logic [7:0]         header_n;
	logic [7:0]         x_byte_n;
	logic signed [15:0] rem_x_n;
	logic signed [15:0] rem_y_n;
	logic [7:0]         cur_x_n;
	logic [7:0]         cur_y_n;
	logic [2:0]         buttons_n;
	logic               done;
	logic               rejected;

	// Axis unit connections.
	logic signed [8:0]  dx;
	logic signed [8:0]  dy;
	logic signed [15:0] ax_rem_x;
	logic signed [15:0] ax_rem_y;
	logic [7:0]         ax_pos_x;
	logic [7:0]         ax_pos_y;

	// The item in the input stage is finished when the result register is free or drains now.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q    <= SCREEN_WIDTH_RST;
			scr_h_q    <= SCREEN_HEIGHT_RST;
			max_step_q <= MAX_STEP_RST;
			visible_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:   scr_w_q    <= cfg_data;
				REG_SCREEN_HEIGHT:  scr_h_q    <= cfg_data;
				REG_MAX_STEP:       max_step_q <= cfg_data[6:0];
				REG_CURSOR_VISIBLE: visible_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The X delta comes from the stored second byte; Y is negated since rows grow downward.
	assign dx = $signed({x_byte_q[7], x_byte_q});
	assign dy = -$signed({item_s1.data_byte[7], item_s1.data_byte});

	ps2mct_axis #(
		.DIVISOR (X_DIVISOR)
	) u_axis_x (
		.rem      (rem_x_q),
		.delta    (dx),
		.max_step (max_step_q),
		.pos      (cur_x_q),
		.size     (scr_w_q),
		.rem_next (ax_rem_x),
		.pos_next (ax_pos_x)
	);

	ps2mct_axis #(
		.DIVISOR (Y_DIVISOR)
	) u_axis_y (
		.rem      (rem_y_q),
		.delta    (dy),
		.max_step (max_step_q),
		.pos      (cur_y_q),
		.size     (scr_h_q),
		.rem_next (ax_rem_y),
		.pos_next (ax_pos_y)
	);

	always_comb begin
		byte_idx_n = byte_idx_q;
		header_n   = header_q;
		x_byte_n   = x_byte_q;
		rem_x_n    = rem_x_q;
		rem_y_n    = rem_y_q;
		cur_x_n    = cur_x_q;
		cur_y_n    = cur_y_q;
		buttons_n  = buttons_q;
		done       = 1'b0;
		rejected   = 1'b0;
		if (item_s1.operation == OP_SET_POS) begin
			cur_x_n = item_s1.set_x;
			cur_y_n = item_s1.set_y;
			rem_x_n = '0;
			rem_y_n = '0;
		end else begin
			case (byte_idx_q)
				2'd0: begin
					header_n   = item_s1.data_byte;
					byte_idx_n = 2'd1;
				end
				2'd1: begin
					x_byte_n   = item_s1.data_byte;
					byte_idx_n = 2'd2;
				end
				default: begin
					// Final byte of the packet; the unused index 3 ends a packet too.
					byte_idx_n = 2'd0;
					done       = 1'b1;
					if (!header_q[HDR_SYNC_BIT]) begin
						rejected = 1'b1;
					end else begin
						rem_x_n   = ax_rem_x;
						rem_y_n   = ax_rem_y;
						cur_x_n   = ax_pos_x;
						cur_y_n   = ax_pos_y;
						buttons_n = header_q[2:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			header_q   <= '0;
			x_byte_q   <= '0;
			rem_x_q    <= '0;
			rem_y_q    <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			buttons_q  <= '0;
		end else if (advance) begin
			byte_idx_q <= byte_idx_n;
			header_q   <= header_n;
			x_byte_q   <= x_byte_n;
			rem_x_q    <= rem_x_n;
			rem_y_q    <= rem_y_n;
			cur_x_q    <= cur_x_n;
			cur_y_q    <= cur_y_n;
			buttons_q  <= buttons_n;
		end
	end

	// Input stage: holds one accepted item until its update is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.pos_x           <= cur_x_n;
			out_q.pos_y           <= cur_y_n;
			out_q.buttons         <= buttons_n;
			out_q.visible         <= visible_q;
			out_q.packet_done     <= done;
			out_q.packet_rejected <= rejected;
		end
	end

`ifndef SYNTHESIS
	// The remainders saturate symmetrically, so the most negative code never appears.
	assert property (@(posedge clk) disable iff (!arst_n) rem_x_q != 16'sh8000)
		else $error("X remainder left its saturation range");
	assert property (@(posedge clk) disable iff (!arst_n) rem_y_q != 16'sh8000)
		else $error("Y remainder left its saturation range");
	// The packet byte counter only counts 0, 1, 2.
	assert property (@(posedge clk) disable iff (!arst_n) byte_idx_q != 2'd3)
		else $error("Packet byte counter reached an unused value");
	// A rejected packet is always a completed packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.packet_rejected |-> out_q.packet_done)
		else $error("Rejected flag without packet completion");
	// A stalled input stage must drain as soon as the result register frees up.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> !valid_s1 || out_valid_q)
		else $error("Input stage did not advance into a free result register");
`endif

endmodule
